>>> hdl/closest_unmarked_point_pair_top_macros.svh
// Assertion macros for the closest unmarked point pair block.
`ifndef CLOSEST_UNMARKED_POINT_PAIR_TOP_MACROS_SVH
`define CLOSEST_UNMARKED_POINT_PAIR_TOP_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define CUPP_ASSERT_IMPLY(label, clk, rst, cond, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (prop)) \
      else $error(msg);

// Next-cycle implication, disabled during reset.
`define CUPP_ASSERT_NEXT(label, clk, rst, cond, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) \
      else $error(msg);

`endif

>>> hdl/cupp_pkg.sv
// Shared constants, types and a helper function of the closest unmarked point pair block.
package cupp_pkg;

   // Table geometry
   localparam int MAX_STARS  = 256;
   localparam int COORD_BITS = 10;
   localparam int IDX_BITS   = $clog2(MAX_STARS);
   localparam int COUNT_W    = $clog2(MAX_STARS + 1);
   localparam int COUNT1_W   = COUNT_W + 1;
   localparam int SQ_W       = 2 * COORD_BITS;
   localparam int DIST_W     = 2 * COORD_BITS + 1;

   // Field widths on the ports
   localparam int ACTION_W   = 2;
   localparam int INDEX_W    = 8;
   localparam int COORD_W    = 10;
   localparam int NAME_W     = 6;
   localparam int SQD_W      = 21;
   localparam int STARCNT_W  = 9;
   localparam int TOL_W      = 10;
   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = 10;

   // Mark succeeds only for names shorter than this
   localparam logic [NAME_W-1:0] NAME_LIMIT = NAME_W'(30);
   localparam logic [TOL_W-1:0]  TOL_RESET  = TOL_W'(1);

   // Action codes
   localparam logic [ACTION_W-1:0] ACT_WRITE = 2'd0;
   localparam logic [ACTION_W-1:0] ACT_MARK  = 2'd1;
   localparam logic [ACTION_W-1:0] ACT_PAIR  = 2'd2;
   localparam logic [ACTION_W-1:0] ACT_FIND  = 2'd3;

   // Register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_STAR_COUNT = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_MATCH_TOL  = 1'd1;

   typedef logic [COORD_BITS-1:0] coord_type;
   typedef logic [IDX_BITS-1:0]   addr_type;
   typedef logic [SQ_W-1:0]       sq_type;

   // One table entry as read from the point memory
   typedef struct packed {
      logic      marked;
      coord_type x;
      coord_type y;
   } point_type;

   // Access to the point memory for one cycle
   typedef struct packed {
      addr_type  rd_addr;
      logic      pt_we;
      logic      mark_we;
      logic      mark_val;
      addr_type  wr_addr;
      coord_type wr_x;
      coord_type wr_y;
   } mem_cmd_type;

   // Sideband carried along the distance pipeline
   typedef struct packed {
      logic     valid;
      logic     marked;
      addr_type idx;
   } tag_type;

   // One result
   typedef struct packed {
      logic               status;
      logic [INDEX_W-1:0] first_index;
      logic [INDEX_W-1:0] second_index;
      logic [SQD_W-1:0]   sq_distance;
   } rsp_type;

   function automatic coord_type abs_diff(coord_type a, coord_type b);
      return (a >= b) ? (a - b) : (b - a);
   endfunction

endpackage

>>> hdl/cupp_ifs.sv
// Request and response channel interfaces of the closest unmarked point pair block.
interface cupp_req_if;
   import cupp_pkg::*;
   logic                valid;
   logic                ready;
   logic [ACTION_W-1:0] action;
   logic [INDEX_W-1:0]  star_index;
   logic [COORD_W-1:0]  coord_x;
   logic [COORD_W-1:0]  coord_y;
   logic [NAME_W-1:0]   name_length;

   modport source (output valid, action, star_index, coord_x, coord_y, name_length,
                   input ready);
   modport sink   (input valid, action, star_index, coord_x, coord_y, name_length,
                   output ready);
endinterface

interface cupp_rsp_if;
   import cupp_pkg::*;
   logic               valid;
   logic               ready;
   logic               status;
   logic [INDEX_W-1:0] first_index;
   logic [INDEX_W-1:0] second_index;
   logic [SQD_W-1:0]   sq_distance;

   modport source (output valid, status, first_index, second_index, sq_distance,
                   input ready);
   modport sink   (input valid, status, first_index, second_index, sq_distance,
                   output ready);
endinterface

>>> hdl/closest_unmarked_point_pair_top.sv
// Top level of the closest unmarked point pair block: sequencer, registers, result slot.
//
// Every request gives exactly one response. Writes and marks are answered from the
// registered response slot and are accepted back to back as long as responses are taken.
// A find-by-coordinates request streams the table through the single read port of the
// point memory, one entry a cycle, and stops at the first entry that matches. A
// closest-pair request is bound by the same read port: for each unmarked pivot i it
// loads the pivot, streams the partners after i and drains the distance pipeline; a
// marked pivot is only loaded and then skipped. No request is taken while a search
// runs. The point table has no reset; entries must be written before use.
`include "closest_unmarked_point_pair_top_macros.svh"

module closest_unmarked_point_pair_top (
   input  logic                               clock,
   input  logic                               reset,
   cupp_req_if.sink                           req_chan,
   cupp_rsp_if.source                         rsp_chan,
   input  logic                               csr_we,
   input  logic [cupp_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [cupp_pkg::CSR_DATA_W-1:0]    csr_wdata
);
   import cupp_pkg::*;

   localparam logic [2:0] ST_IDLE  = 3'd0;
   localparam logic [2:0] ST_FIND  = 3'd1;
   localparam logic [2:0] ST_LOAD  = 3'd2;
   localparam logic [2:0] ST_PIVOT = 3'd3;
   localparam logic [2:0] ST_SCAN  = 3'd4;
   localparam logic [2:0] ST_DRAIN = 3'd5;

   logic [2:0]           state_ff, state_in;
   logic [COUNT_W-1:0]   i_ff, i_in;
   logic [COUNT_W-1:0]   j_ff, j_in;
   logic                 rd_valid_ff, rd_valid_in;
   addr_type             rd_tag_ff, rd_tag_in;
   coord_type            px_ff, px_in, py_ff, py_in;
   coord_type            qx_ff, qx_in, qy_ff, qy_in;
   logic                 best_found_ff, best_found_in;
   logic [DIST_W-1:0]    best_d_ff, best_d_in;
   addr_type             best_i_ff, best_i_in, best_j_ff, best_j_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   rsp_type              rsp_ff, rsp_in;
   logic [STARCNT_W-1:0] star_count_ff;
   logic [TOL_W-1:0]     tol_ff;

   logic                 req_accept;
   logic [COUNT_W-1:0]   n_w;
   logic                 write_ok;
   logic                 mark_ok;
   logic                 find_hit;
   logic                 pair_last;
   logic                 better;
   logic [DIST_W-1:0]    dist_w;
   rsp_type              pair_rsp;
   mem_cmd_type          mem_cmd;
   point_type            rd_pt;
   tag_type              sq_tag_in, sq_tag_out;
   sq_type               sq_x, sq_y;

   cupp_point_mem u_mem (
      .clock (clock),
      .cmd   (mem_cmd),
      .rd_pt (rd_pt)
   );

   cupp_sq_dist u_sq (
      .clock   (clock),
      .reset   (reset),
      .in_tag  (sq_tag_in),
      .ax      (px_ff),
      .ay      (py_ff),
      .bx      (rd_pt.x),
      .by      (rd_pt.y),
      .out_tag (sq_tag_out),
      .sq_x    (sq_x),
      .sq_y    (sq_y)
   );

   // Handshake and decode
   assign req_chan.ready = (state_ff == ST_IDLE) && (!rsp_valid_ff || rsp_chan.ready);
   assign req_accept     = req_chan.valid && req_chan.ready;
   assign n_w = (32'(star_count_ff) > MAX_STARS) ? COUNT_W'(MAX_STARS)
                                                 : COUNT_W'(star_count_ff);
   assign write_ok  = 32'(req_chan.star_index) < MAX_STARS;
   assign mark_ok   = (32'(req_chan.star_index) < 32'(n_w)) &&
                      (req_chan.name_length < NAME_LIMIT);
   assign find_hit  = rd_valid_ff &&
                      (32'(abs_diff(qx_ff, rd_pt.x)) < 32'(tol_ff)) &&
                      (32'(abs_diff(qy_ff, rd_pt.y)) < 32'(tol_ff));
   assign pair_last = (COUNT1_W'(i_ff) + COUNT1_W'(2)) >= COUNT1_W'(n_w);

   // Feed partners to the distance pipeline and compare the finished distance
   assign sq_tag_in.valid  = rd_valid_ff && ((state_ff == ST_SCAN) || (state_ff == ST_DRAIN));
   assign sq_tag_in.marked = rd_pt.marked;
   assign sq_tag_in.idx    = rd_tag_ff;
   assign dist_w = DIST_W'(sq_x) + DIST_W'(sq_y);
   assign better = sq_tag_out.valid && !sq_tag_out.marked &&
                   (!best_found_ff || (dist_w < best_d_ff));

   // Response of a finished pair search
   always_comb begin
      pair_rsp.status       = !best_found_ff;
      pair_rsp.first_index  = best_found_ff ? INDEX_W'(best_i_ff) : '0;
      pair_rsp.second_index = best_found_ff ? INDEX_W'(best_j_ff) : '0;
      pair_rsp.sq_distance  = best_found_ff ? SQD_W'(best_d_ff) : '0;
   end

   // Sequencer
   always_comb begin
      state_in      = state_ff;
      i_in          = i_ff;
      j_in          = j_ff;
      rd_valid_in   = 1'b0;
      rd_tag_in     = i_ff[IDX_BITS-1:0];
      px_in         = px_ff;
      py_in         = py_ff;
      qx_in         = qx_ff;
      qy_in         = qy_ff;
      best_found_in = best_found_ff;
      best_d_in     = best_d_ff;
      best_i_in     = best_i_ff;
      best_j_in     = best_j_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_chan.ready;
      rsp_in        = rsp_ff;
      mem_cmd       = '0;
      mem_cmd.rd_addr  = i_ff[IDX_BITS-1:0];
      mem_cmd.wr_addr  = IDX_BITS'(req_chan.star_index);
      mem_cmd.wr_x     = COORD_BITS'(req_chan.coord_x);
      mem_cmd.wr_y     = COORD_BITS'(req_chan.coord_y);

      // Keep the first strictly smaller distance
      if (better) begin
         best_found_in = 1'b1;
         best_d_in     = dist_w;
         best_i_in     = i_ff[IDX_BITS-1:0];
         best_j_in     = sq_tag_out.idx;
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               case (req_chan.action)
                  ACT_WRITE: begin
                     mem_cmd.pt_we    = write_ok;
                     mem_cmd.mark_we  = write_ok;
                     mem_cmd.mark_val = 1'b0;
                     rsp_valid_in     = 1'b1;
                     rsp_in           = '0;
                     rsp_in.status    = !write_ok;
                  end
                  ACT_MARK: begin
                     mem_cmd.mark_we  = mark_ok;
                     mem_cmd.mark_val = 1'b1;
                     rsp_valid_in     = 1'b1;
                     rsp_in           = '0;
                     rsp_in.status    = !mark_ok;
                  end
                  ACT_PAIR: begin
                     best_found_in = 1'b0;
                     i_in          = '0;
                     if (n_w < COUNT_W'(2)) begin
                        rsp_valid_in  = 1'b1;
                        rsp_in        = '0;
                        rsp_in.status = 1'b1;
                     end else begin
                        state_in = ST_LOAD;
                     end
                  end
                  ACT_FIND: begin
                     qx_in    = COORD_BITS'(req_chan.coord_x);
                     qy_in    = COORD_BITS'(req_chan.coord_y);
                     j_in     = '0;
                     state_in = ST_FIND;
                  end
                  default: begin
                     state_in = ST_IDLE;
                  end
               endcase
            end
         end
         ST_FIND: begin
            mem_cmd.rd_addr = j_ff[IDX_BITS-1:0];
            rd_tag_in       = j_ff[IDX_BITS-1:0];
            if (find_hit) begin
               rsp_valid_in       = 1'b1;
               rsp_in             = '0;
               rsp_in.first_index = INDEX_W'(rd_tag_ff);
               state_in           = ST_IDLE;
            end else if (j_ff < n_w) begin
               rd_valid_in = 1'b1;
               j_in        = j_ff + COUNT_W'(1);
            end else if (!rd_valid_ff) begin
               rsp_valid_in  = 1'b1;
               rsp_in        = '0;
               rsp_in.status = 1'b1;
               state_in      = ST_IDLE;
            end
         end
         ST_LOAD: begin
            rd_valid_in = 1'b1;
            state_in    = ST_PIVOT;
         end
         ST_PIVOT: begin
            if (rd_pt.marked) begin
               if (pair_last) begin
                  rsp_valid_in = 1'b1;
                  rsp_in       = pair_rsp;
                  state_in     = ST_IDLE;
               end else begin
                  i_in     = i_ff + COUNT_W'(1);
                  state_in = ST_LOAD;
               end
            end else begin
               px_in    = rd_pt.x;
               py_in    = rd_pt.y;
               j_in     = i_ff + COUNT_W'(1);
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            mem_cmd.rd_addr = j_ff[IDX_BITS-1:0];
            rd_tag_in       = j_ff[IDX_BITS-1:0];
            rd_valid_in     = 1'b1;
            j_in            = j_ff + COUNT_W'(1);
            if (j_ff == (n_w - COUNT_W'(1))) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            // Wait until every partner of this pivot has been compared
            if (!rd_valid_ff && !sq_tag_in.valid && !sq_tag_out.valid) begin
               if (pair_last) begin
                  rsp_valid_in = 1'b1;
                  rsp_in       = pair_rsp;
                  state_in     = ST_IDLE;
               end else begin
                  i_in     = i_ff + COUNT_W'(1);
                  state_in = ST_LOAD;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         rd_valid_ff   <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         best_found_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         rd_valid_ff   <= rd_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
         best_found_ff <= best_found_in;
      end
   end

   // Payload and counters
   always_ff @(posedge clock) begin
      i_ff      <= i_in;
      j_ff      <= j_in;
      rd_tag_ff <= rd_tag_in;
      px_ff     <= px_in;
      py_ff     <= py_in;
      qx_ff     <= qx_in;
      qy_ff     <= qy_in;
      best_d_ff <= best_d_in;
      best_i_ff <= best_i_in;
      best_j_ff <= best_j_in;
      rsp_ff    <= rsp_in;
   end

   // Configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         star_count_ff <= '0;
         tol_ff        <= TOL_RESET;
      end else if (csr_we) begin
         case (csr_index)
            CSR_STAR_COUNT: star_count_ff <= csr_wdata[STARCNT_W-1:0];
            CSR_MATCH_TOL:  tol_ff        <= csr_wdata[TOL_W-1:0];
            default:        tol_ff        <= tol_ff;
         endcase
      end
   end

   // Drive the response channel
   assign rsp_chan.valid        = rsp_valid_ff;
   assign rsp_chan.status       = rsp_ff.status;
   assign rsp_chan.first_index  = rsp_ff.first_index;
   assign rsp_chan.second_index = rsp_ff.second_index;
   assign rsp_chan.sq_distance  = rsp_ff.sq_distance;

   // Checks
   `CUPP_ASSERT_NEXT(a_quick_rsp, clock, reset, req_accept && (req_chan.action == ACT_WRITE || req_chan.action == ACT_MARK), rsp_chan.valid, "write or mark gave no response")
   `CUPP_ASSERT_IMPLY(a_busy_slot, clock, reset, state_ff != ST_IDLE, !rsp_valid_ff, "response slot full during a search")
   `CUPP_ASSERT_IMPLY(a_pair_order, clock, reset, best_found_ff, best_i_ff < best_j_ff, "closest pair indexes out of order")
   `CUPP_ASSERT_IMPLY(a_scan_bound, clock, reset, state_ff == ST_SCAN, j_ff < n_w, "partner index beyond table")

endmodule

>>> hdl/cupp_point_mem.sv
// Point table: coordinate memory and mark memory, one read and one write each cycle.
module cupp_point_mem (
   input  logic                  clock,
   input  cupp_pkg::mem_cmd_type cmd,
   output cupp_pkg::point_type   rd_pt
);
   import cupp_pkg::*;

   logic [SQ_W-1:0] coord_mem [MAX_STARS];
   logic            mark_mem  [MAX_STARS];
   point_type       rd_pt_ff;

   // Store coordinates and marks
   always_ff @(posedge clock) begin
      if (cmd.pt_we) begin
         coord_mem[cmd.wr_addr] <= {cmd.wr_x, cmd.wr_y};
      end
      if (cmd.mark_we) begin
         mark_mem[cmd.wr_addr] <= cmd.mark_val;
      end
   end

   // Registered read
   always_ff @(posedge clock) begin
      rd_pt_ff.x      <= coord_mem[cmd.rd_addr][SQ_W-1:COORD_BITS];
      rd_pt_ff.y      <= coord_mem[cmd.rd_addr][COORD_BITS-1:0];
      rd_pt_ff.marked <= mark_mem[cmd.rd_addr];
   end

   assign rd_pt = rd_pt_ff;

endmodule

>>> hdl/cupp_sq_dist.sv
// Squared coordinate differences between the pivot point and a streamed partner.
module cupp_sq_dist (
   input  logic                clock,
   input  logic                reset,
   input  cupp_pkg::tag_type   in_tag,
   input  cupp_pkg::coord_type ax,
   input  cupp_pkg::coord_type ay,
   input  cupp_pkg::coord_type bx,
   input  cupp_pkg::coord_type by,
   output cupp_pkg::tag_type   out_tag,
   output cupp_pkg::sq_type    sq_x,
   output cupp_pkg::sq_type    sq_y
);
   import cupp_pkg::*;

   coord_type dx;
   coord_type dy;
   sq_type    sq_x_in;
   sq_type    sq_y_in;
   sq_type    sq_x_ff;
   sq_type    sq_y_ff;
   tag_type   tag_ff;

   // Square each difference
   always_comb begin
      dx      = abs_diff(ax, bx);
      dy      = abs_diff(ay, by);
      sq_x_in = SQ_W'(dx) * SQ_W'(dx);
      sq_y_in = SQ_W'(dy) * SQ_W'(dy);
   end

   // Register squares and sideband
   always_ff @(posedge clock) begin
      if (reset) begin
         tag_ff.valid <= 1'b0;
      end else begin
         tag_ff.valid <= in_tag.valid;
      end
      tag_ff.marked <= in_tag.marked;
      tag_ff.idx    <= in_tag.idx;
      sq_x_ff       <= sq_x_in;
      sq_y_ff       <= sq_y_in;
   end

   assign out_tag = tag_ff;
   assign sq_x    = sq_x_ff;
   assign sq_y    = sq_y_ff;

endmodule
